/* rtl/rrfp_pkg.sv */
// rrfp_pkg: shared types, result codes and the CRC-8 step function
// for the register response frame parser.
// No dependencies.
package rrfp_pkg;

	localparam logic [1:0] KIND_DATA     = 2'd0;
	localparam logic [1:0] KIND_GOOD     = 2'd1;
	localparam logic [1:0] KIND_BADCRC   = 2'd2;
	localparam logic [1:0] KIND_OVERFLOW = 2'd3;

	localparam logic [7:0] PREAMBLE_BYTE = 8'hFB;
	localparam logic [7:0] CRC_INIT      = 8'hFF;
	localparam logic [7:0] CRC_POLY      = 8'h31;
	localparam logic [7:0] COUNT_MASK    = 8'h7F;
	localparam logic [7:0] ADDR_RESET    = 8'h01;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] payload_byte;
		logic [6:0] byte_index;
		logic [7:0] start_register;
		logic [6:0] register_count;
		logic [7:0] payload_length;
	} rrfp_result_t;

	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] r;
		r = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (r[7]) begin
				r = {r[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				r = {r[6:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

/* rtl/rrfp_parser.sv */
// rrfp_parser: input byte register, frame state machine with CRC-8 and
// the address register. Produces at most one result per byte.
// Depends on rrfp_pkg.
module rrfp_parser #(
	parameter int PAYLOAD_MAX_BYTES = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_fire,
	input  logic [7:0]            rx_byte,
	input  logic                  cfg_fire,
	input  logic [7:0]            cfg_data,
	output logic                  valid_s1,
	output logic                  res_valid,
	output rrfp_pkg::rrfp_result_t res
);
	import rrfp_pkg::*;

	localparam int CW = $clog2(PAYLOAD_MAX_BYTES + 1);

	typedef enum logic [2:0] {
		PH_PREAMBLE = 3'd0,
		PH_ADDRESS  = 3'd1,
		PH_STARTREG = 3'd2,
		PH_COUNT    = 3'd3,
		PH_PAYLOAD  = 3'd4,
		PH_CRC      = 3'd5
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  crc_q, crc_d, crc_step;
	logic [7:0]  start_reg_q, start_reg_d;
	logic [6:0]  reg_count_q, reg_count_d;
	logic [CW-1:0] cnt_q, cnt_d, cnt_inc;
	logic [7:0]  addr_q;
	logic [7:0]  byte_s1;
	logic [15:0] len_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= ADDR_RESET;
		end else if (cfg_fire) begin
			addr_q <= cfg_data;
		end
	end

	assign crc_step = crc8_update(crc_q, byte_s1);
	assign cnt_inc  = cnt_q + CW'(1);

	always_comb begin
		phase_d     = phase_q;
		crc_d       = crc_q;
		start_reg_d = start_reg_q;
		reg_count_d = reg_count_q;
		cnt_d       = cnt_q;
		res_valid   = 1'b0;
		res.kind    = KIND_DATA;
		res.payload_byte = 8'd0;
		res.byte_index   = 7'd0;
		len_ext     = 16'(cnt_q);
		case (phase_q)
			PH_ADDRESS: begin
				crc_d   = crc_step;
				phase_d = (byte_s1 == addr_q) ? PH_STARTREG : PH_PREAMBLE;
			end
			PH_STARTREG: begin
				crc_d       = crc_step;
				start_reg_d = byte_s1;
				phase_d     = PH_COUNT;
			end
			PH_COUNT: begin
				crc_d       = crc_step;
				reg_count_d = byte_s1[6:0] & COUNT_MASK[6:0];
				cnt_d       = '0;
				phase_d     = PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				crc_d     = crc_step;
				res_valid = 1'b1;
				if (10'(cnt_q) >= 10'(PAYLOAD_MAX_BYTES)) begin
					phase_d  = PH_PREAMBLE;
					res.kind = KIND_OVERFLOW;
				end else begin
					cnt_d            = cnt_inc;
					len_ext          = 16'(cnt_inc);
					res.payload_byte = byte_s1;
					res.byte_index   = 7'(16'(cnt_q));
					if (10'(cnt_inc) >= 10'({reg_count_q, 2'b00})) begin
						phase_d = PH_CRC;
					end
				end
			end
			PH_CRC: begin
				crc_d     = crc_step;
				phase_d   = PH_PREAMBLE;
				res_valid = 1'b1;
				res.kind  = (crc_step == 8'd0) ? KIND_GOOD : KIND_BADCRC;
			end
			default: begin
				phase_d = PH_PREAMBLE;
				if (byte_s1 == PREAMBLE_BYTE) begin
					crc_d   = crc8_update(CRC_INIT, byte_s1);
					phase_d = PH_ADDRESS;
				end
			end
		endcase
		res.start_register = start_reg_d;
		res.register_count = reg_count_d;
		res.payload_length = len_ext[7:0];
		if (!valid_s1) begin
			res_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_PREAMBLE;
			crc_q       <= 8'd0;
			start_reg_q <= 8'd0;
			reg_count_q <= 7'd0;
			cnt_q       <= '0;
		end else if (valid_s1) begin
			phase_q     <= phase_d;
			crc_q       <= crc_d;
			start_reg_q <= start_reg_d;
			reg_count_q <= reg_count_d;
			cnt_q       <= cnt_d;
		end
	end

endmodule

/* rtl/rrfp_out_buf.sv */
// rrfp_out_buf: three-entry result queue between the parser and the
// output channel; also derives input ready from its fill level.
// Depends on rrfp_pkg.
module rrfp_out_buf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  rrfp_pkg::rrfp_result_t push_data,
	input  logic                  valid_s1,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output rrfp_pkg::rrfp_result_t out_data
);
	import rrfp_pkg::*;

	localparam int DEPTH = 3;

	rrfp_result_t mem_q [DEPTH];
	logic [1:0]   wr_ptr_q, rd_ptr_q, count_q;
	logic         pop;
	logic [2:0]   level;

	assign out_valid = (count_q != 2'd0);
	assign out_data  = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	// worst case: s1 byte pushes this cycle, the new byte pushes next cycle
	assign level     = 3'(count_q) + 3'(valid_s1) - 3'(pop);
	assign in_ready  = (level <= 3'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == 2'(DEPTH - 1)) ? 2'd0 : wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == 2'(DEPTH - 1)) ? 2'd0 : rd_ptr_q + 2'd1;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

/* rtl/register_response_frame_parser_top.sv */
// register_response_frame_parser_top: CRC-8 framed register response parser.
// Depends on rrfp_pkg, rrfp_parser, rrfp_out_buf.
//
//  channel  signals                                   direction
//  in       in_valid/in_ready, rx_byte                sink
//  out      out_valid/out_ready, kind .. payload_length source
//  cfg      cfg_valid/cfg_ready, cfg_data             sink, device address
//
// One byte per cycle sustained while out keeps accepting results. A byte is
// registered, then parsed by the state machine and single-step CRC-8 logic; a
// result is written into the result queue and offered on out from there. A
// three-entry result queue lets input continue while results wait; in_ready
// drops only when the queue could not take the byte in flight. Reset clears
// state; device address resets to 1. cfg_ready is always high.
module register_response_frame_parser_top #(
	parameter int PAYLOAD_MAX_BYTES = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] payload_byte,
	output logic [6:0] byte_index,
	output logic [7:0] start_register,
	output logic [6:0] register_count,
	output logic [7:0] payload_length,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);
	import rrfp_pkg::*;

	logic         valid_s1;
	logic         res_valid;
	rrfp_result_t res;
	rrfp_result_t out_data;

	assign cfg_ready = 1'b1;

	rrfp_parser #(
		.PAYLOAD_MAX_BYTES(PAYLOAD_MAX_BYTES)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_valid && in_ready),
		.rx_byte  (rx_byte),
		.cfg_fire (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.valid_s1 (valid_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	rrfp_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.push_data(res),
		.valid_s1 (valid_s1),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	assign kind           = out_data.kind;
	assign payload_byte   = out_data.payload_byte;
	assign byte_index     = out_data.byte_index;
	assign start_register = out_data.start_register;
	assign register_count = out_data.register_count;
	assign payload_length = out_data.payload_length;

endmodule

/* rtl/rrfp_checker.sv */
// rrfp_checker: port-level assertions for the frame parser top level,
// attached by bind.
// Depends on rrfp_pkg and register_response_frame_parser_top.
module rrfp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] kind,
	input logic [7:0] payload_byte,
	input logic [6:0] byte_index,
	input logic [7:0] payload_length
);
	import rrfp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(payload_byte)
			&& $stable(payload_length))
		else $error("stalled result changed");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_DATA |-> payload_byte == 8'd0 && byte_index == 7'd0)
		else $error("status result carries payload fields");

	a_len_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_DATA |-> payload_length[6:0] == byte_index + 7'd1)
		else $error("payload length does not follow byte index");

	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result present right after reset");

endmodule

bind register_response_frame_parser_top rrfp_checker u_rrfp_checker (.*);

/* tb/sv/tb.sv */
// tb: self-checking testbench for register_response_frame_parser_top.
// Holds a frame-parsing scoreboard with its own CRC-8 predictor and drives the
// byte, result and config channels; depends on rrfp_pkg and the RTL top.
`timescale 1ns / 100ps

module tb;
	import rrfp_pkg::*;

	localparam int PAYLOAD_MAX   = 128;
	localparam int WATCHDOG_MAX  = 4000;
	localparam int SETTLE_CYCLES = 10;

	typedef enum logic [2:0] {
		ST_HUNT, ST_ADDR, ST_SREG, ST_CNT, ST_DATA, ST_CHECK
	} parse_state_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_ready;
	logic [1:0] kind;
	logic [7:0] payload_byte;
	logic [6:0] byte_index;
	logic [7:0] start_register;
	logic [6:0] register_count;
	logic [7:0] payload_length;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] cfg_data;

	bit         steady;
	logic [7:0] cur_addr;
	int         bytes_sent;
	int         idle_cycles;

	// bitwise MSB-first CRC-8, poly 0x31
	function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] r;
		logic       fb;
		r = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = r[7] ^ b[i];
			r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		return r;
	endfunction

	class frame_scoreboard;
		logic [7:0]   dev_addr;
		parse_state_t state;
		logic [7:0]   crc;
		logic [7:0]   hdr_reg;
		logic [6:0]   hdr_cnt;
		int unsigned  held;
		rrfp_result_t expected_q[$];
		int           errors;
		int           n_data;
		int           n_good;
		int           n_bad;
		int           n_ovf;

		function new();
			dev_addr = ADDR_RESET;
			state    = ST_HUNT;
			crc      = '0;
			hdr_reg  = '0;
			hdr_cnt  = '0;
			held     = 0;
			errors   = 0;
			n_data   = 0;
			n_good   = 0;
			n_bad    = 0;
			n_ovf    = 0;
		endfunction

		function void set_address(logic [7:0] a);
			dev_addr = a;
		endfunction

		function void push_result(logic [1:0] k, logic [7:0] data, int unsigned idx);
			rrfp_result_t r;
			r.kind           = k;
			r.payload_byte   = data;
			r.byte_index     = idx[6:0];
			r.start_register = hdr_reg;
			r.register_count = hdr_cnt;
			r.payload_length = held[7:0];
			expected_q.push_back(r);
		endfunction

		// one accepted byte
		function void note_byte(logic [7:0] b);
			case (state)
				ST_ADDR: begin
					crc   = crc_step(crc, b);
					state = (b == dev_addr) ? ST_SREG : ST_HUNT;
				end
				ST_SREG: begin
					crc     = crc_step(crc, b);
					hdr_reg = b;
					state   = ST_CNT;
				end
				ST_CNT: begin
					crc     = crc_step(crc, b);
					hdr_cnt = b[6:0];
					held    = 0;
					state   = ST_DATA;
				end
				ST_DATA: begin
					crc = crc_step(crc, b);
					if (held >= PAYLOAD_MAX) begin
						state = ST_HUNT;
						push_result(KIND_OVERFLOW, 8'h00, 0);
					end else begin
						held++;
						if (held >= 4 * hdr_cnt)
							state = ST_CHECK;
						push_result(KIND_DATA, b, held - 1);
					end
				end
				ST_CHECK: begin
					crc   = crc_step(crc, b);
					state = ST_HUNT;
					push_result((crc == 8'h00) ? KIND_GOOD : KIND_BADCRC, 8'h00, 0);
				end
				default: begin
					state = ST_HUNT;
					if (b == PREAMBLE_BYTE) begin
						crc   = crc_step(CRC_INIT, b);
						state = ST_ADDR;
					end
				end
			endcase
		endfunction

		function void compare_field(string name, logic [7:0] e, logic [7:0] a);
			if (a !== e) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
				errors++;
			end
		endfunction

		function void check_result(rrfp_result_t got);
			rrfp_result_t exp;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0d", $time,
					got.kind);
				errors++;
				return;
			end
			exp = expected_q.pop_front();
			compare_field("kind", exp.kind, got.kind);
			compare_field("payload_byte", exp.payload_byte, got.payload_byte);
			compare_field("byte_index", exp.byte_index, got.byte_index);
			compare_field("start_register", exp.start_register, got.start_register);
			compare_field("register_count", exp.register_count, got.register_count);
			compare_field("payload_length", exp.payload_length, got.payload_length);
			case (exp.kind)
				KIND_DATA:   n_data++;
				KIND_GOOD:   n_good++;
				KIND_BADCRC: n_bad++;
				default:     n_ovf++;
			endcase
		endfunction
	endclass

	frame_scoreboard sb;

	register_response_frame_parser_top #(
		.PAYLOAD_MAX_BYTES(PAYLOAD_MAX)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.payload_byte  (payload_byte),
		.byte_index    (byte_index),
		.start_register(start_register),
		.register_count(register_count),
		.payload_length(payload_length),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// called at a falling edge, returns at a falling edge
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!(in_valid && in_ready));
		sb.note_byte(rx_byte);
		bytes_sent++;
		@(negedge clk);
	endtask

	// keep > 0 cuts the frame after that many bytes
	task automatic send_frame(input logic [7:0] addr, input logic [7:0] sreg,
			input logic [7:0] cbyte, input bit bad_crc, input int keep);
		logic [7:0] fb[$];
		logic [7:0] crc;
		int         n;
		fb = {PREAMBLE_BYTE, addr, sreg, cbyte};
		n  = 4 * cbyte[6:0];
		if (n == 0)
			n = 1;
		if (n > PAYLOAD_MAX)
			n = PAYLOAD_MAX + 1;
		repeat (n) fb.push_back(8'($urandom_range(0, 255)));
		if (n <= PAYLOAD_MAX) begin
			crc = CRC_INIT;
			foreach (fb[i]) crc = crc_step(crc, fb[i]);
			fb.push_back(bad_crc ? crc ^ 8'($urandom_range(1, 255)) : crc);
		end
		if (keep > 0) begin
			while (fb.size() > keep) void'(fb.pop_back());
		end
		foreach (fb[i]) send_byte(fb[i]);
	endtask

	task automatic write_address(input logic [7:0] a);
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= a;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		sb.set_address(a);
		cur_addr = a;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_count();
		int   r;
		logic [6:0] c;
		r = $urandom_range(0, 99);
		if (r < 60)
			c = 7'($urandom_range(0, 3));
		else if (r < 88)
			c = 7'($urandom_range(4, 16));
		else if (r < 95)
			c = 7'($urandom_range(17, 32));
		else
			c = 7'($urandom_range(33, 127));
		return {1'($urandom_range(0, 1)), c};
	endfunction

	task automatic run_random(input int nbytes);
		int stop_at;
		int sel;
		stop_at = bytes_sent + nbytes;
		while (bytes_sent < stop_at) begin
			if ($urandom_range(0, 15) == 0)
				steady = ~steady;
			sel = $urandom_range(0, 99);
			if (sel < 70)
				send_frame(cur_addr, 8'($urandom_range(0, 255)), pick_count(),
					$urandom_range(0, 3) == 0, 0);
			else if (sel < 80)
				send_frame(cur_addr ^ 8'($urandom_range(1, 255)),
					8'($urandom_range(0, 255)), pick_count(), 0, 0);
			else if (sel < 88)
				send_frame(cur_addr, 8'($urandom_range(0, 255)), pick_count(), 0,
					$urandom_range(1, 12));
			else
				repeat ($urandom_range(1, 5))
					send_byte(($urandom_range(0, 3) == 0) ? PREAMBLE_BYTE
						: 8'($urandom_range(0, 255)));
		end
	endtask

	// result side
	initial begin
		rrfp_result_t got;
		int           stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 13);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			got.kind           = kind;
			got.payload_byte   = payload_byte;
			got.byte_index     = byte_index;
			got.start_register = start_register;
			got.register_count = register_count;
			got.payload_length = payload_length;
			sb.check_result(got);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_MAX) begin
				$display("%0t: watchdog expired with %0d results outstanding", $time,
					sb.expected_q.size());
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		rx_byte     = 8'h00;
		cfg_valid   = 1'b0;
		cfg_data    = 8'h00;
		steady      = 1'b0;
		cur_addr    = ADDR_RESET;
		bytes_sent  = 0;
		idle_cycles = 0;
		sb          = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// hunt noise, wrong address, zero count with bit 7 set, bad CRC
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h7F);
		send_frame(8'h02, 8'h10, 8'h01, 0, 2);
		send_frame(ADDR_RESET, 8'hFF, 8'h80, 0, 0);
		send_frame(ADDR_RESET, 8'h00, 8'h01, 1, 0);
		send_frame(ADDR_RESET, 8'h5A, 8'h00, 0, 0);

		run_random(290);
		write_address(8'h00);
		// full buffer exactly, then overflow
		send_frame(cur_addr, 8'hA5, 8'h20, 0, 0);
		send_frame(cur_addr, 8'h3C, 8'hFF, 0, 0);
		run_random(290);
		write_address(8'hFF);
		run_random(290);
		write_address(PREAMBLE_BYTE);
		run_random(290);
		write_address(8'($urandom_range(0, 255)));
		run_random(290);

		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d bytes over five device addresses; checked %0d payload bytes,",
			bytes_sent, sb.n_data);
		$display("%0d good frames, %0d bad-CRC frames, %0d overflow aborts; %0d errors",
			sb.n_good, sb.n_bad, sb.n_ovf, sb.errors);
		if (sb.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
